/* sv/cbts_pkg.sv */
package cbts_pkg;

  // Segment codes as they appear on the result stream
  localparam logic [1:0] SEG_SYNC = 2'd0;
  localparam logic [1:0] SEG_ONE  = 2'd1;
  localparam logic [1:0] SEG_TWO  = 2'd2;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_JUMP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PHASE1_LEN  = 2'd1;
  localparam logic [1:0] REG_PHASE2_LEN  = 2'd2;
  localparam logic [1:0] REG_IDLE_THRESH = 2'd3;

  // Register reset values
  localparam logic [3:0] JUMP_WIDTH_RST  = 4'd2;
  localparam logic [4:0] PHASE1_LEN_RST  = 5'd8;
  localparam logic [4:0] PHASE2_LEN_RST  = 5'd7;
  localparam logic [7:0] IDLE_THRESH_RST = 8'd10;

  localparam int RUN_COUNT_MAX_DEF = 255;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 8;

  // Result item bit positions inside m_tdata
  localparam int OUT_SEG_LSB  = 0;
  localparam int OUT_IDX_LSB  = 2;
  localparam int OUT_STROBE   = 7;
  localparam int OUT_SBIT     = 8;
  localparam int OUT_HARD     = 9;
  localparam int OUT_SOFT     = 10;
  localparam int OUT_WRITE    = 11;

  // Segment limit: length plus adjustment, clamped to 0..31
  function automatic logic [4:0] seg_limit(input logic [4:0] len,
                                           input logic signed [4:0] adj);
    logic signed [6:0] sum;
    sum = $signed({2'b00, len}) + 7'(adj);
    if (sum < 0)
      return 5'd0;
    else if (sum > 7'sd31)
      return 5'd31;
    else
      return sum[4:0];
  endfunction

endpackage

/* sv/can_bit_timing_sync.sv */
// Bit timing and synchronization, one time quantum per input item.
// An accepted item's result item is registered on m_tdata in the next cycle.
// Throughput: one item per cycle unless the output stalls; the next quantum's
// work needs only the segment counters the current item updates in that cycle.
// Reset (rst, synchronous): registers to their defaults, sync segment,
// last sample recessive, recessive run cleared, output stream empty.
module can_bit_timing_sync #(
  parameter int RUN_COUNT_MAX = cbts_pkg::RUN_COUNT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [cbts_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cbts_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] rx_level, [7:1] zero
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] segment, [6:2] quantum_index, [7] sample_strobe, [8] sampled_bit,
  // [9] hard_sync, [10] soft_sync, [11] write_pulse, [15:12] zero
  output logic [cbts_pkg::OUT_DATA_W-1:0] m_tdata
);
  import cbts_pkg::*;

  localparam int RUN_W = $clog2(RUN_COUNT_MAX + 1);
  localparam int CMP_W = (RUN_W > 8) ? RUN_W : 8;
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(RUN_COUNT_MAX);

  typedef enum logic [1:0] {
    ST_SYNC = SEG_SYNC,
    ST_ONE  = SEG_ONE,
    ST_TWO  = SEG_TWO
  } seg_t;

  // Configuration registers
  logic [3:0] jump_width;
  logic [4:0] phase1_length;
  logic [4:0] phase2_length;
  logic [7:0] idle_threshold;

  // Timing state
  seg_t              segment_now, segment_next;
  logic [4:0]        phase1_count, phase1_count_next;
  logic [4:0]        phase2_count, phase2_count_next;
  logic signed [4:0] jump_adjust, jump_adjust_next;
  logic              previous_sample, previous_sample_next;
  logic [RUN_W-1:0]  recessive_run, recessive_run_next;

  // Result fields of the current item
  logic [1:0] o_seg;
  logic [4:0] o_idx;
  logic       o_strobe, o_sbit, o_hard, o_soft;

  logic              accept;
  logic              rx;
  logic              fall_edge, is_hard, is_soft;
  logic [4:0]        cnt1_inc, cnt2_inc;
  logic signed [4:0] adj_pos, adj1, adj2;
  logic [4:0]        lim1, lim2;
  logic [RUN_W-1:0]  run_step;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign rx       = s_tdata[0];

  // Classify the edge and precompute both segment limits
  assign fall_edge = previous_sample && !rx;
  assign is_hard   = fall_edge &&
                     (CMP_W'(recessive_run) > CMP_W'(idle_threshold));
  assign is_soft   = fall_edge && !is_hard;
  assign cnt1_inc  = phase1_count + 5'd1;
  assign cnt2_inc  = phase2_count + 5'd1;
  assign adj_pos   = $signed({1'b0, jump_width});
  assign adj1      = is_soft ? adj_pos : jump_adjust;
  assign adj2      = is_soft ? -adj_pos : jump_adjust;
  assign lim1      = seg_limit(phase1_length, adj1);
  assign lim2      = seg_limit(phase2_length, adj2);
  assign run_step  = rx ? ((recessive_run < RUN_MAX) ? recessive_run + 1'b1
                                                     : recessive_run)
                        : '0;

  // Next state and result fields for one quantum
  always_comb begin
    segment_next         = segment_now;
    phase1_count_next    = phase1_count;
    phase2_count_next    = phase2_count;
    jump_adjust_next     = jump_adjust;
    previous_sample_next = previous_sample;
    recessive_run_next   = recessive_run;
    o_seg    = SEG_SYNC;
    o_idx    = 5'd1;
    o_strobe = 1'b0;
    o_sbit   = 1'b0;
    o_hard   = is_hard;
    o_soft   = is_soft;
    unique case (segment_now)
      ST_ONE: begin
        o_seg            = SEG_ONE;
        o_idx            = cnt1_inc;
        jump_adjust_next = adj1;
        if (is_hard) begin
          previous_sample_next = 1'b0;
          recessive_run_next   = '0;
        end
        // a hard sync restarts the count at zero
        if ((is_hard ? 5'd0 : cnt1_inc) >= lim1) begin
          phase1_count_next = 5'd0;
          jump_adjust_next  = '0;
          segment_next      = ST_TWO;
        end else begin
          phase1_count_next = is_hard ? 5'd0 : cnt1_inc;
        end
      end
      ST_TWO: begin
        o_seg = SEG_TWO;
        o_idx = cnt2_inc;
        if (is_hard) begin
          previous_sample_next = 1'b0;
          recessive_run_next   = '0;
        end
        // sample point overrides what a hard sync cleared
        if (cnt2_inc == 5'd1) begin
          o_strobe             = 1'b1;
          o_sbit               = rx;
          previous_sample_next = rx;
          recessive_run_next   = run_step;
        end
        if (is_hard) begin
          jump_adjust_next  = '0;
          phase2_count_next = 5'd0;
          segment_next      = ST_ONE;
        end else if (cnt2_inc >= lim2) begin
          jump_adjust_next  = '0;
          phase2_count_next = 5'd0;
          segment_next      = ST_SYNC;
        end else begin
          jump_adjust_next  = adj2;
          phase2_count_next = cnt2_inc;
        end
      end
      default: begin
        // sync segment, and the unused code treated the same way
        segment_next = ST_ONE;
      end
    endcase
  end

  // Hold configuration, timing state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_width      <= JUMP_WIDTH_RST;
      phase1_length   <= PHASE1_LEN_RST;
      phase2_length   <= PHASE2_LEN_RST;
      idle_threshold  <= IDLE_THRESH_RST;
      segment_now     <= ST_SYNC;
      phase1_count    <= 5'd0;
      phase2_count    <= 5'd0;
      jump_adjust     <= '0;
      previous_sample <= 1'b1;
      recessive_run   <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_JUMP_WIDTH:  jump_width     <= cfg_data[3:0];
          REG_PHASE1_LEN:  phase1_length  <= cfg_data[4:0];
          REG_PHASE2_LEN:  phase2_length  <= cfg_data[4:0];
          REG_IDLE_THRESH: idle_threshold <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        segment_now     <= segment_next;
        phase1_count    <= phase1_count_next;
        phase2_count    <= phase2_count_next;
        jump_adjust     <= jump_adjust_next;
        previous_sample <= previous_sample_next;
        recessive_run   <= recessive_run_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Load the result payload when an item is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'd0, o_hard, o_soft, o_hard, o_sbit, o_strobe, o_idx, o_seg};
    end
  end

endmodule

/* sv/cbts_checker.sv */
module cbts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cbts_pkg::OUT_DATA_W-1:0] m_tdata
);
  import cbts_pkg::*;

  // Stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // Output side empty right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Input taken whenever the result register can drain
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free result register");

  // Sample point only in phase two, sampled bit only there
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_STROBE] || m_tdata[OUT_SBIT]) |->
      m_tdata[OUT_STROBE] && (m_tdata[OUT_SEG_LSB+1:OUT_SEG_LSB] == SEG_TWO))
    else $error("sample outside phase two");

  // Hard and soft sync exclusive; write pulse equals hard sync
  a_sync: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[OUT_HARD] && m_tdata[OUT_SOFT]) &&
                 (m_tdata[OUT_WRITE] == m_tdata[OUT_HARD]))
    else $error("sync flags inconsistent");

endmodule

bind can_bit_timing_sync cbts_checker u_cbts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cbts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 2000;

  // One expected result item per time quantum
  typedef struct packed {
    logic [1:0] seg;
    logic [4:0] idx;
    logic       strobe;
    logic       sbit;
    logic       hard_sy;
    logic       soft_sy;
    logic       wr_pulse;
  } quantum_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [0] rx_level, [7:1] zero
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [1:0] segment, [6:2] quantum_index, [7] sample_strobe, [8] sampled_bit,
  // [9] hard_sync, [10] soft_sync, [11] write_pulse, [15:12] zero
  logic [OUT_DATA_W-1:0] m_tdata;

  // Bus levels waiting to be sent, and results still owed by the block
  logic            quanta_q[$];
  quantum_result_t results_due[$];
  int              queued_total = 0;
  int              mismatches   = 0;
  int              cycle_cnt    = 0;
  logic            idle_on      = 1'b1;
  logic            s_fire       = 1'b0;

  // Shadow of the timing registers
  logic [3:0] sjw      = JUMP_WIDTH_RST;
  logic [4:0] len1     = PHASE1_LEN_RST;
  logic [4:0] len2     = PHASE2_LEN_RST;
  logic [7:0] idle_lim = IDLE_THRESH_RST;

  // Shadow of the bit timing state
  logic [1:0] seg_now  = SEG_SYNC;
  logic [4:0] p1_cnt   = '0;
  logic [4:0] p2_cnt   = '0;
  int         jump_adj = 0;
  logic       last_bit = 1'b1;
  logic [7:0] rec_run  = '0;

  can_bit_timing_sync uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Segment end point: length plus jump, clamped to 0..31
  function automatic logic [4:0] seg_end(input logic [4:0] len, input int adj);
    int v;
    v = int'(len) + adj;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return v[4:0];
  endfunction

  // Advance the timing state by one quantum and return its result item
  function automatic quantum_result_t advance_quantum(input logic rx);
    quantum_result_t r;
    logic fall_seen;
    logic hard_due;
    r = '0;
    fall_seen = last_bit && !rx;
    hard_due  = fall_seen && (rec_run > idle_lim);
    case (seg_now)
      SEG_ONE: begin
        r.seg  = SEG_ONE;
        p1_cnt = p1_cnt + 5'd1;
        r.idx  = p1_cnt;
        if (fall_seen) begin
          if (hard_due) begin
            r.hard_sy  = 1'b1;
            r.wr_pulse = 1'b1;
            p1_cnt     = '0;
            last_bit   = 1'b0;
            rec_run    = '0;
          end else begin
            r.soft_sy = 1'b1;
            jump_adj  = int'(sjw);
          end
        end
        if (p1_cnt >= seg_end(len1, jump_adj)) begin
          p1_cnt   = '0;
          jump_adj = 0;
          seg_now  = SEG_TWO;
        end
      end
      SEG_TWO: begin
        r.seg  = SEG_TWO;
        p2_cnt = p2_cnt + 5'd1;
        r.idx  = p2_cnt;
        if (fall_seen) begin
          if (hard_due) begin
            r.hard_sy  = 1'b1;
            r.wr_pulse = 1'b1;
            last_bit   = 1'b0;
            rec_run    = '0;
          end else begin
            r.soft_sy = 1'b1;
            jump_adj  = -int'(sjw);
          end
        end
        // sample point: first quantum of phase two
        if (p2_cnt == 5'd1) begin
          r.strobe = 1'b1;
          r.sbit   = rx;
          last_bit = rx;
          if (rx) begin
            if (int'(rec_run) < RUN_COUNT_MAX_DEF) rec_run = rec_run + 8'd1;
          end else begin
            rec_run = '0;
          end
        end
        if (r.hard_sy) begin
          jump_adj = 0;
          p2_cnt   = '0;
          seg_now  = SEG_ONE;
        end else if (p2_cnt >= seg_end(len2, jump_adj)) begin
          jump_adj = 0;
          p2_cnt   = '0;
          seg_now  = SEG_SYNC;
        end
      end
      default: begin
        // sync segment: flags only, no length change
        r.seg = SEG_SYNC;
        r.idx = 5'd1;
        if (fall_seen) begin
          if (hard_due) begin
            r.hard_sy  = 1'b1;
            r.wr_pulse = 1'b1;
          end else begin
            r.soft_sy = 1'b1;
          end
        end
        seg_now = SEG_ONE;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Source driver: present the next bus level, with random gaps
  always @(negedge clk) begin
    int src_gap;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_fire) begin
      // hold until taken
    end else if (src_gap > 0) begin
      src_gap--;
      s_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      src_gap = $urandom_range(0, 3);
      s_tvalid <= 1'b0;
    end else if (quanta_q.size() != 0) begin
      s_tdata  <= {{(IN_DATA_W-1){1'b0}}, quanta_q.pop_front()};
      s_tvalid <= 1'b1;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Sink: random stall bursts on the result stream
  always @(negedge clk) begin
    int snk_gap;
    if (snk_gap > 0) begin
      snk_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    quantum_result_t e;
    s_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      results_due.push_back(advance_quantum(s_tdata[0]));
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("result item 0x%04h with no expectation waiting", m_tdata);
        mismatches++;
      end else begin
        e = results_due.pop_front();
        check_field("segment", e.seg, m_tdata[OUT_SEG_LSB +: 2]);
        check_field("quantum_index", e.idx, m_tdata[OUT_IDX_LSB +: 5]);
        check_field("sample_strobe", e.strobe, m_tdata[OUT_STROBE]);
        check_field("sampled_bit", e.sbit, m_tdata[OUT_SBIT]);
        check_field("hard_sync", e.hard_sy, m_tdata[OUT_HARD]);
        check_field("soft_sync", e.soft_sy, m_tdata[OUT_SOFT]);
        check_field("write_pulse", e.wr_pulse, m_tdata[OUT_WRITE]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_JUMP_WIDTH:  sjw      = val[3:0];
      REG_PHASE1_LEN:  len1     = val[4:0];
      REG_PHASE2_LEN:  len2     = val[4:0];
      REG_IDLE_THRESH: idle_lim = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int jw, input int p1, input int p2, input int thr);
    write_reg(REG_JUMP_WIDTH, 8'(jw));
    write_reg(REG_PHASE1_LEN, 8'(p1));
    write_reg(REG_PHASE2_LEN, 8'(p2));
    write_reg(REG_IDLE_THRESH, 8'(thr));
  endtask

  task automatic push_level(input logic lvl, input int n);
    repeat (n) quanta_q.push_back(lvl);
    queued_total += n;
  endtask

  // One nominal bit time, jittered by up to two quanta
  task automatic push_bit(input logic lvl);
    int len;
    len = 1 + int'(len1) + int'(len2) + int'($urandom_range(0, 4)) - 2;
    if (len < 1) len = 1;
    push_level(lvl, len);
  endtask

  // Mostly frames (recessive idle, start bit, payload), some noise and glitches
  task automatic gen_traffic(input int n);
    int stop_at;
    int kind;
    int nbits;
    int cap;
    int k;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // long bits get a brief idle and payload
        if (1 + int'(len1) + int'(len2) > 12) begin
          cap = 1;
        end else begin
          cap = int'(idle_lim) + 2;
          if (cap > 12) cap = 12;
        end
        nbits = $urandom_range(0, cap);
        for (k = 0; k < nbits; k++) push_bit(1'b1);
        push_bit(1'b0);
        if (1 + int'(len1) + int'(len2) > 12) nbits = $urandom_range(1, 2);
        else nbits = $urandom_range(2, 8);
        for (k = 0; k < nbits; k++) push_bit(1'($urandom_range(0, 1)));
      end else if (kind < 9) begin
        nbits = $urandom_range(1, 8);
        for (k = 0; k < nbits; k++) push_level(1'($urandom_range(0, 1)), 1);
      end else begin
        push_level(1'b1, $urandom_range(1, 6));
        push_level(1'b0, 1);
        push_level(1'b1, $urandom_range(1, 3));
      end
    end
  endtask

  // Wait until every item is sent and every result has come back
  task automatic drain();
    int waited;
    waited = 0;
    while (quanta_q.size() != 0 || s_tvalid) @(posedge clk);
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected result items never arrived", results_due.size());
      mismatches++;
      results_due.delete();
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timing: edge in sync, soft syncs in both phases
    push_level(1'b0, 3);
    push_level(1'b1, 10);
    push_level(1'b0, 3);
    drain();

    // One-quantum segments, widest jump, zero threshold: hard syncs everywhere
    set_timing(15, 1, 1, 0);
    push_level(1'b1, 4);
    push_level(1'b0, 1);
    push_level(1'b1, 3);
    push_level(1'b0, 2);
    push_level(1'b1, 2);
    gen_traffic(40);
    drain();

    // Threshold 254: recessive runs stay below it, every edge is soft
    set_timing(0, 1, 1, 254);
    push_level(1'b1, 30);
    gen_traffic(20);
    drain();

    // Segments of 16 quanta, no jump
    set_timing(0, 16, 16, 3);
    gen_traffic(40);
    drain();

    // Segments of 16 quanta, widest jump
    set_timing(15, 16, 16, 1);
    gen_traffic(40);
    drain();

    // Random mid settings
    set_timing($urandom_range(0, 15), $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(0, 6));
    gen_traffic(30);
    drain();

    // Last part at full rate, no gaps or stalls
    idle_on = 1'b0;
    set_timing($urandom_range(0, 15), $urandom_range(1, 8), $urandom_range(1, 8),
               $urandom_range(0, 4));
    gen_traffic(30);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* can_bit_timing_sync.f */
sv/cbts_pkg.sv
sv/can_bit_timing_sync.sv
sv/cbts_checker.sv
test/tb_top.sv
